// ===== rtl/vtsr_pkg.sv =====
// Shared types and constants for the video timing and scroll register unit.
// No dependencies; used by vtsr_core, vtsr_obuf and the top level.
`default_nettype none

package vtsr_pkg;

  // Item kinds carried in the slave-side tuser
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // Register numbers within the register window
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // Raster geometry
  localparam logic [8:0] DOT_LAST      = 9'd340;
  localparam logic [8:0] DOT_SKIP      = 9'd339;
  localparam logic [8:0] LINE_PRE      = 9'd261;
  localparam logic [8:0] LINE_VBL      = 9'd241;
  localparam logic [8:0] LINE_VISIBLE  = 9'd240;
  localparam logic [8:0] DOT_RESET     = 9'd340;
  localparam logic [8:0] LINE_RESET    = 9'd240;

  // Address copy masks
  localparam logic [15:0] VCOPY_MASK = 16'h7BE0;
  localparam logic [15:0] HCOPY_MASK = 16'h041F;

  localparam logic [3:0] NMI_DELAY = 4'd15;

  // One result item
  typedef struct packed {
    logic        in_vblank;
    logic [8:0]  scanline;
    logic [8:0]  dot;
    logic [2:0]  fine_scroll_x;
    logic [15:0] vram_address;
    logic        nmi_request;
    logic [7:0]  read_data;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/vtsr_obuf.sv =====
// Two-entry result buffer (output register plus skid register).
// Depends on vtsr_pkg for the result struct.
`default_nettype none

module vtsr_obuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire vtsr_pkg::result_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output vtsr_pkg::result_t     out_data_o
);

  logic              out_valid_q, skid_valid_q;
  vtsr_pkg::result_t out_data_q, skid_data_q;
  logic              push, pop, out_free;

  assign in_ready_o  = ~skid_valid_q;
  assign push        = in_valid_i & ~skid_valid_q;
  assign pop         = out_valid_q & out_ready_i;
  assign out_free    = ~out_valid_q | pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload: skid drains first, then fresh transfers
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (push) begin
        out_data_q <= in_data_i;
      end
    end else if (push) begin
      skid_data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vtsr_core.sv =====
// Raster counters, loopy scroll registers and vblank/NMI logic; one item per cycle while accept_i is high.
// Depends on vtsr_pkg for kinds, register numbers, constants and the result struct.
`default_nettype none

module vtsr_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [1:0]       kind_i,
  input  wire logic [2:0]       reg_index_i,
  input  wire logic [7:0]       write_data_i,
  input  wire logic             sprite_overflow_i,
  input  wire logic             sprite_zero_hit_i,
  output vtsr_pkg::result_t     result_o
);

  logic [8:0]  dot_q, dot_d, line_q, line_d;
  logic        odd_q, odd_d;
  logic [15:0] cur_q, cur_d, temp_q, temp_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic        toggle_q, toggle_d;
  logic [7:0]  last_q, last_d;
  logic        nmi_en_q, nmi_en_d, row_step_q, row_step_d;
  logic        show_bg_q, show_bg_d, show_spr_q, show_spr_d;
  logic        vblank_q, vblank_d, nmi_prev_q, nmi_prev_d;
  logic [3:0]  nmi_cnt_q, nmi_cnt_d;
  logic [7:0]  rd;
  logic        pulse, rendering, pre, render, fetch;

  function automatic logic [15:0] coarse_x(input logic [15:0] a);
    logic [15:0] r;
    r = a;
    if (a[4:0] == 5'd31) begin
      r[4:0] = 5'd0;
      r[10]  = ~a[10];
    end else begin
      r = a + 16'd1;
    end
    return r;
  endfunction

  function automatic logic [15:0] coarse_y(input logic [15:0] a);
    logic [15:0] r;
    logic [4:0]  row;
    r = a;
    if (a[14:12] != 3'd7) begin
      r[14:12] = a[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      row = a[9:5];
      if (row == 5'd29) begin
        row   = 5'd0;
        r[11] = ~a[11];
      end else if (row == 5'd31) begin
        row = 5'd0;
      end else begin
        row = row + 5'd1;
      end
      r[9:5] = row;
    end
    return r;
  endfunction

  // Next-state logic, in the order the item's effects apply
  always_comb begin
    dot_d      = dot_q;
    line_d     = line_q;
    odd_d      = odd_q;
    cur_d      = cur_q;
    temp_d     = temp_q;
    fine_x_d   = fine_x_q;
    toggle_d   = toggle_q;
    last_d     = last_q;
    nmi_en_d   = nmi_en_q;
    row_step_d = row_step_q;
    show_bg_d  = show_bg_q;
    show_spr_d = show_spr_q;
    vblank_d   = vblank_q;
    nmi_prev_d = nmi_prev_q;
    nmi_cnt_d  = nmi_cnt_q;
    rd         = 8'd0;
    pulse      = 1'b0;
    rendering  = show_bg_q | show_spr_q;
    pre        = 1'b0;
    render     = 1'b0;
    fetch      = 1'b0;

    unique case (kind_i)
      vtsr_pkg::KIND_TICK: begin
        // NMI delay countdown
        if (nmi_cnt_q != 4'd0) begin
          nmi_cnt_d = nmi_cnt_q - 4'd1;
          pulse     = (nmi_cnt_q == 4'd1) & nmi_en_q & vblank_q;
        end
        // Raster advance with the odd-frame dot skip
        if (rendering && odd_q && line_q == vtsr_pkg::LINE_PRE &&
            dot_q == vtsr_pkg::DOT_SKIP) begin
          dot_d  = 9'd0;
          line_d = 9'd0;
          odd_d  = ~odd_q;
        end else if (dot_q >= vtsr_pkg::DOT_LAST) begin
          dot_d = 9'd0;
          if (line_q >= vtsr_pkg::LINE_PRE) begin
            line_d = 9'd0;
            odd_d  = ~odd_q;
          end else begin
            line_d = line_q + 9'd1;
          end
        end else begin
          dot_d = dot_q + 9'd1;
        end
        pre    = line_d == vtsr_pkg::LINE_PRE;
        render = pre | (line_d < vtsr_pkg::LINE_VISIBLE);
        fetch  = (dot_d >= 9'd321 && dot_d <= 9'd336) ||
                 (dot_d >= 9'd1 && dot_d <= 9'd256);
        // Scroll increments and copies while rendering
        if (rendering) begin
          if (pre && dot_d >= 9'd280 && dot_d <= 9'd304) begin
            cur_d = (cur_d & ~vtsr_pkg::VCOPY_MASK) | (temp_q & vtsr_pkg::VCOPY_MASK);
          end
          if (render) begin
            if (fetch && dot_d[2:0] == 3'd0) cur_d = coarse_x(cur_d);
            if (dot_d == 9'd256) cur_d = coarse_y(cur_d);
            if (dot_d == 9'd257) begin
              cur_d = (cur_d & ~vtsr_pkg::HCOPY_MASK) | (temp_q & vtsr_pkg::HCOPY_MASK);
            end
          end
        end
        // Vblank set/clear; set and clear dots never coincide
        if (line_d == vtsr_pkg::LINE_VBL && dot_d == 9'd1) begin
          vblank_d = 1'b1;
        end else if (pre && dot_d == 9'd1) begin
          vblank_d = 1'b0;
        end
        if ((line_d == vtsr_pkg::LINE_VBL || pre) && dot_d == 9'd1) begin
          if (nmi_en_q && vblank_d && !nmi_prev_q) nmi_cnt_d = vtsr_pkg::NMI_DELAY;
          nmi_prev_d = nmi_en_q & vblank_d;
        end
      end
      vtsr_pkg::KIND_WRITE: begin
        last_d = write_data_i;
        unique case (reg_index_i)
          vtsr_pkg::REG_CTRL: begin
            row_step_d     = write_data_i[2];
            nmi_en_d       = write_data_i[7];
            temp_d[11:10]  = write_data_i[1:0];
            if (write_data_i[7] && vblank_q && !nmi_prev_q) nmi_cnt_d = vtsr_pkg::NMI_DELAY;
            nmi_prev_d     = write_data_i[7] & vblank_q;
          end
          vtsr_pkg::REG_MASK: begin
            show_bg_d  = write_data_i[3];
            show_spr_d = write_data_i[4];
          end
          vtsr_pkg::REG_SCROLL: begin
            if (!toggle_q) begin
              temp_d[4:0] = write_data_i[7:3];
              fine_x_d    = write_data_i[2:0];
            end else begin
              temp_d[14:12] = write_data_i[2:0];
              temp_d[9:5]   = write_data_i[7:3];
            end
            toggle_d = ~toggle_q;
          end
          vtsr_pkg::REG_ADDR: begin
            if (!toggle_q) begin
              temp_d[13:8] = write_data_i[5:0];
              temp_d[14]   = 1'b0;
            end else begin
              temp_d[7:0] = write_data_i;
              cur_d       = {temp_q[15:8], write_data_i};
            end
            toggle_d = ~toggle_q;
          end
          vtsr_pkg::REG_DATA: cur_d = cur_q + (row_step_q ? 16'd32 : 16'd1);
          default: ;
        endcase
      end
      vtsr_pkg::KIND_READ: begin
        if (reg_index_i == vtsr_pkg::REG_STATUS) begin
          rd         = {vblank_q, sprite_zero_hit_i, sprite_overflow_i, last_q[4:0]};
          vblank_d   = 1'b0;
          toggle_d   = 1'b0;
          nmi_prev_d = 1'b0;
        end else if (reg_index_i == vtsr_pkg::REG_DATA) begin
          cur_d = cur_q + (row_step_q ? 16'd32 : 16'd1);
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q      <= vtsr_pkg::DOT_RESET;
      line_q     <= vtsr_pkg::LINE_RESET;
      odd_q      <= 1'b0;
      cur_q      <= 16'd0;
      temp_q     <= 16'd0;
      fine_x_q   <= 3'd0;
      toggle_q   <= 1'b0;
      last_q     <= 8'd0;
      nmi_en_q   <= 1'b0;
      row_step_q <= 1'b0;
      show_bg_q  <= 1'b0;
      show_spr_q <= 1'b0;
      vblank_q   <= 1'b0;
      nmi_prev_q <= 1'b0;
      nmi_cnt_q  <= 4'd0;
    end else if (accept_i) begin
      dot_q      <= dot_d;
      line_q     <= line_d;
      odd_q      <= odd_d;
      cur_q      <= cur_d;
      temp_q     <= temp_d;
      fine_x_q   <= fine_x_d;
      toggle_q   <= toggle_d;
      last_q     <= last_d;
      nmi_en_q   <= nmi_en_d;
      row_step_q <= row_step_d;
      show_bg_q  <= show_bg_d;
      show_spr_q <= show_spr_d;
      vblank_q   <= vblank_d;
      nmi_prev_q <= nmi_prev_d;
      nmi_cnt_q  <= nmi_cnt_d;
    end
  end

  // Result fields reflect the state after this item
  always_comb begin
    result_o.read_data     = rd;
    result_o.nmi_request   = pulse;
    result_o.vram_address  = cur_d;
    result_o.fine_scroll_x = fine_x_d;
    result_o.dot           = dot_d;
    result_o.scanline      = line_d;
    result_o.in_vblank     = vblank_d;
  end

endmodule

`default_nettype wire

// ===== rtl/video_timing_scroll_register_unit_core.sv =====
// Top level of the video timing and scroll register unit.
// Depends on vtsr_pkg, vtsr_core (state update) and vtsr_obuf (result buffer).
//
//   channel   dir  contents
//   s_axis    in   tuser = kind; tdata = reg_index, write_data, overflow, zero hit
//   m_axis    out  tdata = read_data, nmi_request, vram_address, fine_scroll_x,
//                  dot, scanline, in_vblank
//
// One item per clock; its result is registered in the output buffer. The state
// update is a single pass of combinational logic on the item and the state
// registers. A two-entry output buffer keeps input open while one result waits;
// input stalls only when both entries are full.
// Reset puts the raster at line 240 dot 340 with all scroll and flag state clear.
`default_nettype none

module video_timing_scroll_register_unit_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] reg_index, [10:3] write_data, [11] sprite_overflow_in,
  // [12] sprite_zero_hit_in, [15:13] zero
  input  wire logic [15:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [8] nmi_request, [24:9] vram_address, [27:25] fine_scroll_x,
  // [36:28] dot, [45:37] scanline, [46] in_vblank, [47] zero
  output logic [47:0]      m_axis_tdata
);

  logic              accept;
  vtsr_pkg::result_t result, out_result;

  assign accept = s_axis_tvalid & s_axis_tready;

  vtsr_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .kind_i            (s_axis_tuser),
    .reg_index_i       (s_axis_tdata[2:0]),
    .write_data_i      (s_axis_tdata[10:3]),
    .sprite_overflow_i (s_axis_tdata[11]),
    .sprite_zero_hit_i (s_axis_tdata[12]),
    .result_o          (result)
  );

  vtsr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_result)
  );

  // Struct packs lowest field last, so it maps straight onto tdata
  assign m_axis_tdata = {1'b0, out_result};

endmodule

`default_nettype wire
